/* rtl/bdlp_pkg.sv */
// Shared types and constants for the button debounce / long-press core.
// Field widths, register indexes, reset values and result codes.
// No dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

  // Field widths
  localparam int unsigned CountW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;  // raw_level + time_ms = 33 bits
  localparam int unsigned OutDataW = 8;   // action + feedback = 4 bits

  // Configuration port widths
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 32;

  // Register indexes
  localparam logic [CfgIndexW-1:0] RegDebounceTicks = 8'd0;
  localparam logic [CfgIndexW-1:0] RegPortalHoldMs  = 8'd1;
  localparam logic [CfgIndexW-1:0] RegResetHoldMs   = 8'd2;
  localparam logic [CfgIndexW-1:0] RegStartPressed  = 8'd3;

  // Register reset values
  localparam logic [CountW-1:0] DebounceTicksRst = 8'd5;
  localparam logic [TimeW-1:0]  PortalHoldMsRst  = 32'd3000;
  localparam logic [TimeW-1:0]  ResetHoldMsRst   = 32'd10000;
  localparam logic              StartPressedRst  = 1'b0;

  // Action / feedback codes
  typedef enum logic [CodeW-1:0] {
    GRADE_NONE   = 2'd0,
    GRADE_PORTAL = 2'd1,
    GRADE_RESET  = 2'd2
  } grade_t;

endpackage

/* rtl/button_debounce_long_press_core.sv */
// Top level of the button debounce / long-press core.
// Debounce counter, press timer, threshold grading and output register.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

// Each input beat is one sample tick: tdata bit 0 is the raw button level
// (1 = pressed) and bits 32:1 a free-running millisecond timestamp. Every
// accepted beat produces exactly one output beat carrying action (on the
// debounced release: none, portal or reset) and feedback (while held: the
// highest threshold passed). The level is debounced by debounce_ticks equal
// samples; a button held at start (start_pressed) is ignored until its first
// debounced release, and writing start_pressed reloads the start state.
// Each output beat appears in the cycle after its input beat, and one beat can be
// taken every clock: the debounce compare, the 32-bit hold-time subtract and
// the two threshold compares sit between the sample state and the output
// register. The input is stalled only while an output beat waits unread.
// Configuration writes are always ready and take effect at once; write them
// only while no beat is in flight.
module button_debounce_long_press_core (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bdlp_pkg::InDataW-1:0]     s_axis_tdata,   // [0] raw_level, [32:1] time_ms
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bdlp_pkg::OutDataW-1:0]    m_axis_tdata,   // [1:0] action, [3:2] feedback
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdlp_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]    cfg_data
);

  import bdlp_pkg::*;

  // Configuration registers
  logic [CountW-1:0] debounce_ticks;
  logic [TimeW-1:0]  portal_hold_ms;
  logic [TimeW-1:0]  reset_hold_ms;
  logic              start_pressed;

  // Sample state
  logic              ignore_until_release;
  logic              last_raw;
  logic [CountW-1:0] stable_count;
  logic              stable_level;
  logic              prev_pressed;
  logic [TimeW-1:0]  press_start_time;

  // Next-state values for one accepted beat
  logic              ignore_next;
  logic [CountW-1:0] stable_count_next;
  logic              stable_level_next;
  logic [TimeW-1:0]  press_start_time_next;
  grade_t            action_next;
  grade_t            feedback_next;

  // Output register
  grade_t            action;
  grade_t            feedback;

  logic              raw_in;
  logic [TimeW-1:0]  now_in;
  logic [CountW-1:0] count_base;
  logic [TimeW-1:0]  held;
  grade_t            held_grade;
  logic              in_beat;
  logic              cfg_beat;
  logic              start_load;

  assign raw_in = s_axis_tdata[0];
  assign now_in = s_axis_tdata[TimeW:1];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_beat      = cfg_valid && cfg_ready;
  assign start_load    = cfg_beat && (cfg_index == RegStartPressed);

  // Debounce, press timing and grading for the incoming sample
  always_comb begin
    count_base = (raw_in != last_raw) ? '0 : stable_count;
    stable_count_next = count_base;
    stable_level_next = stable_level;
    if (count_base < debounce_ticks) begin
      stable_count_next = count_base + 1'b1;
      if (stable_count_next >= debounce_ticks) begin
        stable_level_next = raw_in;
      end
    end

    ignore_next           = ignore_until_release;
    press_start_time_next = press_start_time;
    if (!ignore_until_release && stable_level_next && !prev_pressed) begin
      press_start_time_next = now_in;
    end
    held = now_in - press_start_time_next;

    if (held >= reset_hold_ms) begin
      held_grade = GRADE_RESET;
    end else if (held >= portal_hold_ms) begin
      held_grade = GRADE_PORTAL;
    end else begin
      held_grade = GRADE_NONE;
    end

    action_next   = GRADE_NONE;
    feedback_next = GRADE_NONE;
    if (ignore_until_release) begin
      if (!stable_level_next) begin
        ignore_next = 1'b0;
      end
    end else if (stable_level_next) begin
      feedback_next = held_grade;
    end else if (prev_pressed) begin
      action_next = held_grade;
    end
  end

  // Configuration, sample state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks       <= DebounceTicksRst;
      portal_hold_ms       <= PortalHoldMsRst;
      reset_hold_ms        <= ResetHoldMsRst;
      start_pressed        <= StartPressedRst;
      ignore_until_release <= StartPressedRst;
      last_raw             <= StartPressedRst;
      stable_count         <= DebounceTicksRst;
      stable_level         <= StartPressedRst;
      prev_pressed         <= StartPressedRst;
      press_start_time     <= '0;
      m_axis_tvalid        <= 1'b0;
    end else begin
      m_axis_tvalid <= in_beat || (m_axis_tvalid && !m_axis_tready);
      if (cfg_beat) begin
        case (cfg_index)
          RegDebounceTicks: debounce_ticks <= cfg_data[CountW-1:0];
          RegPortalHoldMs:  portal_hold_ms <= cfg_data[TimeW-1:0];
          RegResetHoldMs:   reset_hold_ms  <= cfg_data[TimeW-1:0];
          RegStartPressed:  start_pressed  <= cfg_data[0];
          default: ;
        endcase
      end
      if (start_load) begin
        // reload the start state with the new level
        ignore_until_release <= cfg_data[0];
        last_raw             <= cfg_data[0];
        stable_count         <= debounce_ticks;
        stable_level         <= cfg_data[0];
        prev_pressed         <= cfg_data[0];
        press_start_time     <= '0;
      end else if (in_beat) begin
        ignore_until_release <= ignore_next;
        last_raw             <= raw_in;
        stable_count         <= stable_count_next;
        stable_level         <= stable_level_next;
        prev_pressed         <= stable_level_next;
        press_start_time     <= press_start_time_next;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      action   <= action_next;
      feedback <= feedback_next;
    end
  end

  assign m_axis_tdata = {{(OutDataW - 2*CodeW){1'b0}}, feedback, action};

`ifndef SYNTHESIS
  // a beat always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // release action and hold feedback are exclusive
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (action == GRADE_NONE || feedback == GRADE_NONE))
    else $error("action and feedback both set");

  // an ignored press reports nothing
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_beat && ignore_until_release && !cfg_beat)
      |=> (action == GRADE_NONE && feedback == GRADE_NONE))
    else $error("output while ignoring held button");

  // no action unless the debounced level just fell
  a_action_on_release: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !cfg_beat && !(prev_pressed && !stable_level_next))
      |=> action == GRADE_NONE)
    else $error("action without a debounced release");

  // start_pressed write reloads the state
  a_start_load: assert property (@(posedge clk) disable iff (rst)
    (cfg_beat && cfg_index == RegStartPressed)
      |=> (stable_level == start_pressed && ignore_until_release == start_pressed))
    else $error("start state not reloaded");
`endif

endmodule
